@@ design/fragment_retransmit_scoreboard_top_assert.svh @@
// Assertion macros for the checker of the scoreboard.
// Both macros sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef FRAGMENT_RETRANSMIT_SCOREBOARD_TOP_ASSERT_SVH
`define FRAGMENT_RETRANSMIT_SCOREBOARD_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scoreboard check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scoreboard check failed");

`endif

@@ design/frs_pkg.sv @@
package frs_pkg;

  // Field widths of the item and result channels.
  localparam int FUNC_W     = 2;
  localparam int NOW_W      = 32;
  localparam int PART_W     = 8;
  localparam int PAYLOAD_W  = 16;
  localparam int TOTAL_W    = 24;
  localparam int INTERVAL_W = 32;
  localparam int LEN_W      = 17;
  localparam int IDX_OUT_W  = 8;

  // The product of a fragment index and a fragment step fits in 25 bits.
  localparam int OFF_W      = 25;

  // A live fragment count of up to 256 needs nine bits.
  localparam int CNT_W      = 9;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Fragment marks: zero is never sent, all ones is finished.
  localparam int MARK_W = 32;
  localparam logic [MARK_W-1:0] MARK_DONE = 32'hFFFF_FFFF;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 16'd500;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_ACK   = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PART_COUNT      = 2'd0,
    CFG_PAYLOAD_SIZE    = 2'd1,
    CFG_TOTAL_LENGTH    = 2'd2,
    CFG_RESEND_INTERVAL = 2'd3
  } cfg_reg_e;

endpackage

@@ design/frs_in_if.sv @@
interface frs_in_if;
  import frs_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NOW_W-1:0]  now;
  logic              resend;
  logic [PART_W-1:0] part;

  modport source (output valid, output func, output now, output resend, output part,
                  input ready);
  modport sink   (input valid, input func, input now, input resend, input part,
                  output ready);
endinterface

@@ design/frs_out_if.sv @@
interface frs_out_if;
  import frs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [IDX_OUT_W-1:0] fragment_index;
  logic [TOTAL_W-1:0]   byte_offset;
  logic [LEN_W-1:0]     byte_length;
  logic                 all_acked;

  modport source (output valid, output found, output fragment_index, output byte_offset,
                  output byte_length, output all_acked, input ready);
  modport sink   (input valid, input found, input fragment_index, input byte_offset,
                  input byte_length, input all_acked, output ready);
endinterface

@@ design/frs_geom.sv @@
module frs_geom #(
  parameter int MAX_PARTS    = 256,
  parameter int HEADER_BYTES = 8,
  localparam int IdxW        = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [IdxW-1:0]                idx_i,
  input  logic [frs_pkg::PAYLOAD_W-1:0]  payload_size_i,
  input  logic [frs_pkg::TOTAL_W-1:0]    total_length_i,
  output logic                           done_o,
  output logic [frs_pkg::TOTAL_W-1:0]    byte_offset_o,
  output logic [frs_pkg::LEN_W-1:0]      byte_length_o
);
  import frs_pkg::*;

  logic [LEN_W-1:0]   step;
  logic [OFF_W-1:0]   remain;
  logic [OFF_W-1:0]   prod_q;
  logic [LEN_W-1:0]   step_q;
  logic               s1_q;
  logic               s2_q;
  logic [TOTAL_W-1:0] off_q;
  logic [LEN_W-1:0]   len_q;

  // One fragment occupies its header plus its payload in the buffer.
  assign step = LEN_W'(payload_size_i) + LEN_W'(HEADER_BYTES);

  // Bytes left in the buffer from the fragment's offset, saturating at zero.
  assign remain = (OFF_W'(total_length_i) > prod_q) ? OFF_W'(total_length_i) - prod_q
                                                     : '0;

  // Stage one multiplies, stage two clips the length to what remains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      prod_q <= '0;
      step_q <= '0;
      off_q  <= '0;
      len_q  <= '0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      prod_q <= OFF_W'(idx_i) * OFF_W'(step);
      step_q <= step;
      off_q  <= prod_q[TOTAL_W-1:0];
      len_q  <= (OFF_W'(step_q) < remain) ? step_q : remain[LEN_W-1:0];
    end
  end

  assign done_o        = s2_q;
  assign byte_offset_o = off_q;
  assign byte_length_o = len_q;

endmodule

@@ design/fragment_retransmit_scoreboard_top.sv @@
// Scoreboard for the fragments of one outgoing datagram. Each fragment has a
// 32-bit mark in an on-chip memory of MAX_PARTS words (zero: never sent, all
// ones: finished, else the tick of its last resend). A start item clears all
// marks at once through a per-entry valid vector. A get item reads the marks
// one per cycle from fragment zero upward and stops at the first eligible one,
// whose offset is then multiplied out and its length clipped. An acknowledge
// item is a read, compare and write back of one mark. One item is worked on at
// a time; the finished result sits in an output register, so the next item is
// taken while the previous result waits. Configuration is to be written by
// the user only while idle; the block itself does not enforce it.
module fragment_retransmit_scoreboard_top #(
  parameter int MAX_PARTS    = 256,
  parameter int HEADER_BYTES = 8,
  localparam int IdxW        = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [frs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [frs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  frs_in_if.sink                          inp_i,
  frs_out_if.source                       res_o
);
  import frs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GEOM,
    S_ACK,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [PART_W-1:0]     part_count_q;
  logic [PAYLOAD_W-1:0]  payload_size_q;
  logic [TOTAL_W-1:0]    total_length_q;
  logic [INTERVAL_W-1:0] resend_interval_q;

  // Scoreboard state besides the marks.
  logic                  armed_q;
  logic [PART_W-1:0]     unacked_q;

  // Item being worked on.
  logic [NOW_W-1:0]      now_q;
  logic                  resend_q;
  logic [IdxW-1:0]       idx_q;

  // Staged result and output register.
  logic                  res_found_q;
  logic [IDX_OUT_W-1:0]  res_idx_q;
  logic [TOTAL_W-1:0]    res_off_q;
  logic [LEN_W-1:0]      res_len_q;
  logic                  res_all_q;
  logic                  out_vld_q;
  logic                  out_found_q;
  logic [IDX_OUT_W-1:0]  out_idx_q;
  logic [TOTAL_W-1:0]    out_off_q;
  logic [LEN_W-1:0]      out_len_q;
  logic                  out_all_q;

  // Mark memory and its per-entry valid bits.
  logic [MARK_W-1:0]     mark_mem [MAX_PARTS];
  logic [MAX_PARTS-1:0]  vld_q;
  logic [MARK_W-1:0]     rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;
  logic [MARK_W-1:0]     wr_data;

  logic                  accept;
  logic                  out_free;
  logic [CNT_W-1:0]      live_cnt;
  logic [MARK_W-1:0]     mark;
  logic                  elig;
  logic                  scan_last;
  logic                  get_go;
  logic                  ack_go;
  logic [IdxW-1:0]       ack_addr;
  logic                  clear_all;
  logic                  geom_start;
  logic                  geom_done;
  logic [TOTAL_W-1:0]    geom_off;
  logic [LEN_W-1:0]      geom_len;

  assign inp_i.ready = (state_q == S_IDLE);
  assign accept      = inp_i.valid & inp_i.ready;
  assign out_free    = !out_vld_q || res_o.ready;

  // Fragments in use: the part count, limited to the memory depth.
  assign live_cnt = (CNT_W'(part_count_q) > CNT_W'(MAX_PARTS)) ? CNT_W'(MAX_PARTS)
                                                               : CNT_W'(part_count_q);

  // An entry not written since the last start reads as never sent.
  assign mark = rd_vld_q ? rd_data_q : '0;

  assign elig = (mark != MARK_DONE) &&
                (resend_q ? ((now_q - mark) >= resend_interval_q) : (mark == '0));

  assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == live_cnt);

  assign get_go   = armed_q && (live_cnt != '0);
  assign ack_go   = armed_q && (inp_i.part != '0) && (CNT_W'(inp_i.part) <= live_cnt) &&
                    (unacked_q != '0);
  assign ack_addr = IdxW'(inp_i.part - PART_W'(1));

  assign clear_all  = accept && (inp_i.func == FUNC_START);
  assign geom_start = (state_q == S_SCAN) && elig;

  // Memory read port: first mark of a scan, the acknowledged mark, or the
  // next mark while the scan goes on.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept && (inp_i.func == FUNC_GET) && get_go) begin
      rd_en = 1'b1;
    end else if (accept && (inp_i.func == FUNC_ACK) && ack_go) begin
      rd_en   = 1'b1;
      rd_addr = ack_addr;
    end else if ((state_q == S_SCAN) && !elig && !scan_last) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + IdxW'(1);
    end
  end

  // Memory write port: stamp a resend pick, mark a first pick or an ack finished.
  // Items are handled one at a time, so a write always lands before any
  // later read of the same entry.
  assign wr_en   = geom_start || ((state_q == S_ACK) && (mark != MARK_DONE));
  assign wr_data = ((state_q == S_SCAN) && resend_q) ? now_q : MARK_DONE;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mark_mem[idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mark_mem[rd_addr];
    end
  end

  // Valid bits: a start clears them all, a write sets its entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clear_all) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q      <= '0;
      payload_size_q    <= PAYLOAD_RESET;
      total_length_q    <= '0;
      resend_interval_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PART_COUNT:      part_count_q      <= cfg_data_i[PART_W-1:0];
        CFG_PAYLOAD_SIZE:    payload_size_q    <= cfg_data_i[PAYLOAD_W-1:0];
        CFG_TOTAL_LENGTH:    total_length_q    <= cfg_data_i[TOTAL_W-1:0];
        CFG_RESEND_INTERVAL: resend_interval_q <= cfg_data_i[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset and clipped length of the selected fragment.
  frs_geom #(
    .MAX_PARTS    (MAX_PARTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (geom_start),
    .idx_i          (idx_q),
    .payload_size_i (payload_size_q),
    .total_length_i (total_length_q),
    .done_o         (geom_done),
    .byte_offset_o  (geom_off),
    .byte_length_o  (geom_len)
  );

  // Sequencer with the result staging and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      unacked_q   <= '0;
      now_q       <= '0;
      resend_q    <= 1'b0;
      idx_q       <= '0;
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      res_off_q   <= '0;
      res_len_q   <= '0;
      res_all_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_idx_q   <= '0;
      out_off_q   <= '0;
      out_len_q   <= '0;
      out_all_q   <= 1'b0;
    end else begin
      // The output register takes a finished result, or empties once its item is taken.
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q   <= 1'b1;
        out_found_q <= res_found_q;
        out_idx_q   <= res_idx_q;
        out_off_q   <= res_off_q;
        out_len_q   <= res_len_q;
        out_all_q   <= res_all_q;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            now_q       <= inp_i.now;
            resend_q    <= inp_i.resend;
            res_found_q <= 1'b0;
            res_idx_q   <= '0;
            res_off_q   <= '0;
            res_len_q   <= '0;
            res_all_q   <= 1'b0;
            case (inp_i.func)
              FUNC_START: begin
                armed_q   <= 1'b1;
                unacked_q <= live_cnt[PART_W-1:0];
                state_q   <= S_DONE;
              end
              FUNC_GET: begin
                idx_q   <= '0;
                state_q <= get_go ? S_SCAN : S_DONE;
              end
              FUNC_ACK: begin
                idx_q   <= ack_addr;
                state_q <= ack_go ? S_ACK : S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (elig) begin
            state_q <= S_GEOM;
          end else if (scan_last) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_GEOM: begin
          if (geom_done) begin
            res_found_q <= 1'b1;
            res_idx_q   <= IDX_OUT_W'(idx_q);
            res_off_q   <= geom_off;
            res_len_q   <= geom_len;
            state_q     <= S_DONE;
          end
        end
        S_ACK: begin
          if (mark != MARK_DONE) begin
            unacked_q <= unacked_q - PART_W'(1);
            res_all_q <= (unacked_q == PART_W'(1));
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.found          = out_found_q;
  assign res_o.fragment_index = out_idx_q;
  assign res_o.byte_offset    = out_off_q;
  assign res_o.byte_length    = out_len_q;
  assign res_o.all_acked      = out_all_q;

endmodule

@@ design/frs_checker.sv @@
`include "fragment_retransmit_scoreboard_top_assert.svh"

module frs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            found_i,
  input logic [frs_pkg::IDX_OUT_W-1:0]   fragment_index_i,
  input logic [frs_pkg::TOTAL_W-1:0]     byte_offset_i,
  input logic [frs_pkg::LEN_W-1:0]       byte_length_i,
  input logic                            all_acked_i
);
  import frs_pkg::*;

  // A stalled result keeps its selection.
  `FRS_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(fragment_index_i) && $stable(byte_offset_i))

  // Only an acknowledge reports completion, and it never selects a fragment.
  `FRS_ASSERT_NOW(a_ack_excl, out_valid_i && all_acked_i, !found_i)

  // Without a selection the fragment fields stay zero.
  `FRS_ASSERT_NOW(a_nofind_zero, out_valid_i && !found_i, (fragment_index_i == '0) && (byte_offset_i == '0) && (byte_length_i == '0))

  // The first fragment always starts at the head of the buffer.
  `FRS_ASSERT_NOW(a_first_offset, out_valid_i && found_i && (fragment_index_i == '0), byte_offset_i == '0)

endmodule

bind fragment_retransmit_scoreboard_top frs_checker u_frs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .found_i          (res_o.found),
  .fragment_index_i (res_o.fragment_index),
  .byte_offset_i    (res_o.byte_offset),
  .byte_length_i    (res_o.byte_length),
  .all_acked_i      (res_o.all_acked)
);
